### rtl/core/ssc_pkg.sv
// shared constants, types and the crc-8 byte update for the scratchpad checker
// no dependencies
`timescale 1ns / 1ps

package ssc_pkg;

   // bytes in one scratchpad frame, the last one carries the crc
   localparam int FRAME_BYTES = 9;
   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   localparam logic [7:0] CRC_POLY = 8'h8C;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ALL_ZERO = 2'd1,
      STATUS_CRC      = 2'd2
   } status_type;

   typedef struct packed {
      logic              last;
      status_type        status;
      logic signed [15:0] temperature;
   } result_type;

   // reflected crc-8, lsb first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_i, input logic [7:0] data_i);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc_i;
      d = data_i;
      for (int k = 0; k < 8; k++) begin
         mix = c[0] ^ d[0];
         c = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

### rtl/core/ssc_frame_tracker.sv
// frame state of the scratchpad checker: byte position, running crc, nonzero flag
// and the two temperature bytes; depends on ssc_pkg
`timescale 1ns / 1ps

module ssc_frame_tracker (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   output ssc_pkg::result_type result
);

   localparam logic [ssc_pkg::POS_W-1:0] POS_W_ONE = ssc_pkg::POS_W'(1);

   logic [ssc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                crc_ff, crc_in;
   logic                      nonzero_ff, nonzero_in;
   logic [7:0]                low_ff, low_in;
   logic [7:0]                high_ff, high_in;
   logic                      is_last;
   logic                      nonzero_now;

   assign is_last     = (pos_ff == ssc_pkg::LAST_POS);
   assign nonzero_now = nonzero_ff | (data_byte != 8'd0);

   always_comb begin
      result.last        = is_last;
      result.temperature = '0;
      if (!nonzero_now) begin
         result.status = ssc_pkg::STATUS_ALL_ZERO;
      end else if (crc_ff != data_byte) begin
         result.status = ssc_pkg::STATUS_CRC;
      end else begin
         result.status      = ssc_pkg::STATUS_OK;
         result.temperature = {high_ff, low_ff};
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      nonzero_in = nonzero_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      if (step) begin
         if (is_last) begin
            pos_in     = '0;
            crc_in     = '0;
            nonzero_in = 1'b0;
            low_in     = '0;
            high_in    = '0;
         end else begin
            pos_in     = pos_ff + 1'b1;
            crc_in     = ssc_pkg::crc8_byte(crc_ff, data_byte);
            nonzero_in = nonzero_now;
            if (pos_ff == '0) begin
               low_in = data_byte;
            end
            if (pos_ff == POS_W_ONE) begin
               high_in = data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= '0;
         nonzero_ff <= 1'b0;
         low_ff     <= '0;
         high_ff    <= '0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         nonzero_ff <= nonzero_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
      end
   end

   a_clear_after_frame: assert property (@(posedge clock) disable iff (reset)
      step && is_last |=> pos_ff == '0 && crc_ff == 8'd0 && !nonzero_ff)
      else $error("frame state not cleared after last byte");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= ssc_pkg::LAST_POS)
      else $error("byte position beyond frame");

   a_pos_advances: assert property (@(posedge clock) disable iff (reset)
      step && !is_last |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("byte position did not advance");

endmodule

### rtl/core/sensor_scratchpad_checker.sv
// top level of the scratchpad frame checker: input register, frame tracker,
// result register; depends on ssc_pkg and ssc_frame_tracker
//
//  channel | ports                                   | direction
//  req     | req_valid, req_stall, req_data_byte     | byte in, one per transaction
//  rsp     | rsp_valid, rsp_stall, rsp_status,       | one result per frame
//          | rsp_temperature                         |
//
// a byte goes into the input register and is folded into the frame state from
// there; a frame result is registered for rsp. While req_stall stays low, the
// sustained rate is one byte per cycle, set by the one-byte crc update.
// reset is synchronous and clears the frame state and both valid flags.
// rsp_stall holds the result register; only a last byte waits behind it,
// so req_stall rises only while a last byte cannot hand off its result.
`timescale 1ns / 1ps

module sensor_scratchpad_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_temperature
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                out_valid_ff, out_valid_in;
   ssc_pkg::status_type out_status_ff, out_status_in;
   logic signed [15:0]  out_temp_ff, out_temp_in;
   ssc_pkg::result_type result;
   logic                out_free;
   logic                process;

   ssc_frame_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step      (process),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && (!result.last || out_free);
   assign req_stall = in_valid_ff && !process;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_temp_in   = out_temp_ff;
      if (process && result.last) begin
         out_valid_in  = 1'b1;
         out_status_in = result.status;
         out_temp_in   = result.temperature;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      out_status_ff <= out_status_in;
      out_temp_ff   <= out_temp_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_temperature = out_temp_ff;

   a_bad_status_zero_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ssc_pkg::STATUS_OK |-> rsp_temperature == 16'sd0)
      else $error("temperature not zero on failed frame");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_stall_only_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && result.last && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

### sim/tb_sensor_scratchpad_checker.sv
// self-checking testbench for sensor_scratchpad_checker: drives scratchpad bytes,
// predicts each frame result internally and compares it with rsp
// depends on ssc_pkg and the rtl of sensor_scratchpad_checker
`timescale 1ns / 1ps

module tb_sensor_scratchpad_checker;

   localparam int LAST_BYTE   = ssc_pkg::FRAME_BYTES - 1;
   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_BYTES = 1560;

   typedef struct {
      ssc_pkg::status_type status;
      logic signed [15:0]  temperature;
   } reading_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [15:0] rsp_temperature;

   // predicted frame state
   logic [3:0] pos_q = '0;
   logic [7:0] crc_q = '0;
   logic       any_nonzero_q = 1'b0;
   logic [7:0] temp_lo_q = '0;
   logic [7:0] temp_hi_q = '0;

   reading_type pending_readings[$];
   logic [7:0]  frame_body [LAST_BYTE];

   int  error_count = 0;
   int  bytes_sent = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;

   sensor_scratchpad_checker u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_temperature (rsp_temperature)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      acc = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         acc = acc[0] ? ((acc >> 1) ^ ssc_pkg::CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   // advance the predicted frame state by one accepted byte
   function automatic void fold_scratchpad_byte(input logic [7:0] b);
      reading_type r;
      if (b != 8'h00) begin
         any_nonzero_q = 1'b1;
      end
      if (pos_q < LAST_BYTE) begin
         if (pos_q == 4'd0) begin
            temp_lo_q = b;
         end else if (pos_q == 4'd1) begin
            temp_hi_q = b;
         end
         crc_q = crc8_step(crc_q, b);
         pos_q = pos_q + 4'd1;
      end else begin
         // zero frame takes priority over the crc compare
         if (!any_nonzero_q) begin
            r.status = ssc_pkg::STATUS_ALL_ZERO;
         end else if (crc_q != b) begin
            r.status = ssc_pkg::STATUS_CRC;
         end else begin
            r.status = ssc_pkg::STATUS_OK;
         end
         r.temperature = (r.status == ssc_pkg::STATUS_OK) ? {temp_hi_q, temp_lo_q} : 16'sd0;
         pending_readings.push_back(r);
         pos_q = '0;
         crc_q = '0;
         any_nonzero_q = 1'b0;
         temp_lo_q = '0;
         temp_hi_q = '0;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (req_idle_on && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      fold_scratchpad_byte(b);
      bytes_sent++;
   endtask

   // sends frame_body followed by its crc, xor-ed with crc_flip
   task automatic send_frame(input logic [7:0] crc_flip);
      logic [7:0] crc;
      crc = '0;
      for (int i = 0; i < LAST_BYTE; i++) begin
         crc = crc8_step(crc, frame_body[i]);
         send_byte(frame_body[i]);
      end
      send_byte(crc ^ crc_flip);
   endtask

   task automatic fill_body(input logic [7:0] value);
      for (int i = 0; i < LAST_BYTE; i++) begin
         frame_body[i] = value;
      end
   endtask

   task automatic fill_body_random();
      for (int i = 0; i < LAST_BYTE; i++) begin
         frame_body[i] = 8'($urandom_range(0, 255));
      end
   endtask

   task automatic test_directed_frames();
      // all-zero frame passes the crc but must be flagged
      fill_body(8'h00);
      send_frame(8'h00);
      // most negative temperature, good crc
      fill_body(8'hFF);
      frame_body[0] = 8'h00;
      frame_body[1] = 8'h80;
      send_frame(8'h00);
      // most positive temperature but a bad crc, temperature reads zero
      fill_body(8'hA5);
      frame_body[0] = 8'hFF;
      frame_body[1] = 8'h7F;
      send_frame(8'h01);
   endtask

   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int f = 0; f < 40; f++) begin
         fill_body_random();
         send_frame((f % 5 == 4) ? 8'h80 : 8'h00);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // receiver holds off long enough for a finished result to block the input
   task automatic test_output_hold();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_requests++;
      for (int f = 0; f < 6; f++) begin
         fill_body_random();
         send_frame(8'h00);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random_frames(input int target);
      int kind;
      int n;
      while (bytes_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            fill_body_random();
            send_frame(8'h00);
         end else if (kind < 68) begin
            // one nonzero byte somewhere in the body
            fill_body(8'h00);
            frame_body[$urandom_range(0, LAST_BYTE - 1)] = 8'($urandom_range(1, 255));
            send_frame(8'h00);
         end else if (kind < 76) begin
            fill_body(8'h00);
            send_frame(8'h00);
         end else if (kind < 82) begin
            // zero body, only the crc byte nonzero
            fill_body(8'h00);
            send_frame(8'($urandom_range(1, 255)));
         end else if (kind < 90) begin
            fill_body_random();
            send_frame(8'($urandom_range(1, 255)));
         end else begin
            // broken sequence across frame boundaries, then realign
            n = $urandom_range(1, 20);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            while (pos_q != 4'd0) begin
               send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result checker and receiver stall
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("error: unexpected result status=%0d temperature=%0d",
                        rsp_status, rsp_temperature);
            end
         end else begin
            want = pending_readings.pop_front();
            if (rsp_status !== want.status || rsp_temperature !== want.temperature) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("error: status exp %0d got %0d, temperature exp %0d got %0d",
                           want.status, rsp_status, want.temperature, rsp_temperature);
               end
            end
         end
      end
      rsp_stall <= (hold_left > 0) || (rsp_idle_on && $urandom_range(0, 99) < 26);
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_back_to_back();
      test_output_hold();
      test_random_frames(bytes_sent + RANDOM_BYTES);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS sensor_scratchpad_checker");
      end else begin
         $display("FAIL sensor_scratchpad_checker");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL sensor_scratchpad_checker");
      $finish;
   end

endmodule
